@@ rtl/dnle_pkg.sv @@
// dnle_pkg: shared types and constants for the DNS name label encoder.
// Used by dnle_front, dnle_queue, dnle_back and the top level; no dependencies.

package dnle_pkg;

   // width of the label character count (holds up to 63)
   localparam int CNT_W = 6;

   // dot separating labels
   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // zero terminator byte
   localparam logic [7:0] TERM_BYTE = 8'h00;

   // request function codes (travel on req_tuser)
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // label close command passed from front to back
   typedef struct packed {
      logic             is_end;   // close of the final label, terminator follows
      logic             dropped;  // characters were dropped in this name
      logic             bank;     // label memory bank holding the characters
      logic [CNT_W-1:0] count;    // characters held in the bank
   } cmd_type;

   // write into the label memory
   typedef struct packed {
      logic             we;
      logic             bank;
      logic [CNT_W-1:0] idx;
      logic [7:0]       data;
   } mem_wr_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      BK_LEN,
      BK_CHAR,
      BK_TERM
   } back_state_type;

endpackage

@@ rtl/dnle_front.sv @@
// dnle_front: accepts name characters, fills the label memory bank and issues
// label close commands. Depends on dnle_pkg.

module dnle_front #(
   parameter int LABEL_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   input  logic [7:0]           req_tdata,
   input  logic                 q_full,
   output logic                 push,
   output dnle_pkg::cmd_type    push_cmd,
   output dnle_pkg::mem_wr_type mem_wr
);

   logic [dnle_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       dropped_ff, dropped_in;
   logic                       bank_ff, bank_in;
   logic                       accept;

   // both banks busy only when two closes are queued
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // classify the request
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      bank_in    = bank_ff;
      push       = 1'b0;
      push_cmd   = '{is_end: 1'b0, dropped: 1'b0, bank: bank_ff, count: count_ff};
      mem_wr     = '{we: 1'b0, bank: bank_ff, idx: count_ff, data: req_tdata};
      if (accept) begin
         if (req_tuser == dnle_pkg::FUNC_END) begin
            push            = 1'b1;
            push_cmd.is_end = 1'b1;
            push_cmd.dropped = dropped_ff;
            count_in        = '0;
            dropped_in      = 1'b0;
            bank_in         = !bank_ff;
         end else if (req_tdata == dnle_pkg::DOT_CHAR) begin
            push     = 1'b1;
            count_in = '0;
            bank_in  = !bank_ff;
         end else if (count_ff < dnle_pkg::CNT_W'(LABEL_MAX)) begin
            mem_wr.we = 1'b1;
            count_in  = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   // front state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         bank_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         bank_ff    <= bank_in;
      end
   end

endmodule

@@ rtl/dnle_queue.sv @@
// dnle_queue: two-entry command queue between front and back.
// Depends on dnle_pkg.

module dnle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dnle_pkg::cmd_type push_cmd,
   input  logic              pop,
   output dnle_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   dnle_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (fill_ff == 2'd0);
   assign full  = (fill_ff == 2'd2);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/dnle_back.sv @@
// dnle_back: label memory and output sequencer; emits length, characters and
// terminator bytes through an output register. Depends on dnle_pkg.

module dnle_back #(
   parameter int LABEL_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dnle_pkg::mem_wr_type mem_wr,
   input  dnle_pkg::cmd_type    head,
   input  logic                 q_empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   localparam int MEM_DEPTH = 2 * LABEL_MAX;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic [7:0]                 mem [MEM_DEPTH];
   logic [7:0]                 rd_data_ff;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic                       ren;
   logic [dnle_pkg::CNT_W-1:0] rd_idx;

   dnle_pkg::back_state_type   state_ff, state_in;
   logic [dnle_pkg::CNT_W-1:0] k_ff, k_in;
   logic [dnle_pkg::CNT_W-1:0] k_next;

   logic                       can_load, ld;
   logic [7:0]                 ld_byte;
   logic                       ld_last, ld_ovf;
   logic                       out_valid_ff;
   logic [7:0]                 out_byte_ff;
   logic                       out_last_ff, out_ovf_ff;

   // bank 1 sits above bank 0
   assign wr_addr = ADDR_W'(mem_wr.idx) + (mem_wr.bank ? ADDR_W'(LABEL_MAX) : '0);
   assign rd_addr = ADDR_W'(rd_idx) + (head.bank ? ADDR_W'(LABEL_MAX) : '0);

   // label memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr.we) begin
         mem[wr_addr] <= mem_wr.data;
      end
      if (ren) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign can_load = !out_valid_ff || rsp_tready;
   assign k_next   = k_ff + 1'b1;

   // sequencer: length byte, characters, terminator
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pop      = 1'b0;
      ren      = 1'b0;
      rd_idx   = '0;
      ld       = 1'b0;
      ld_byte  = dnle_pkg::TERM_BYTE;
      ld_last  = 1'b0;
      ld_ovf   = 1'b0;
      case (state_ff)
         dnle_pkg::BK_LEN: begin
            if (!q_empty && can_load) begin
               ld      = 1'b1;
               ld_byte = 8'(head.count);
               if (head.count != '0) begin
                  ren      = 1'b1;
                  k_in     = '0;
                  state_in = dnle_pkg::BK_CHAR;
               end else if (head.is_end) begin
                  state_in = dnle_pkg::BK_TERM;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         dnle_pkg::BK_CHAR: begin
            if (can_load) begin
               ld      = 1'b1;
               ld_byte = rd_data_ff;
               if (k_next < head.count) begin
                  ren    = 1'b1;
                  rd_idx = k_next;
                  k_in   = k_next;
               end else if (head.is_end) begin
                  state_in = dnle_pkg::BK_TERM;
               end else begin
                  pop      = 1'b1;
                  state_in = dnle_pkg::BK_LEN;
               end
            end
         end
         dnle_pkg::BK_TERM: begin
            if (can_load) begin
               ld       = 1'b1;
               ld_byte  = dnle_pkg::TERM_BYTE;
               ld_last  = 1'b1;
               ld_ovf   = head.dropped;
               pop      = 1'b1;
               state_in = dnle_pkg::BK_LEN;
            end
         end
         default: begin
            state_in = dnle_pkg::BK_LEN;
         end
      endcase
   end

   // sequencer and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnle_pkg::BK_LEN;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (ld) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (ld) begin
         out_byte_ff <= ld_byte;
         out_last_ff <= ld_last;
         out_ovf_ff  <= ld_ovf;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

@@ rtl/dns_name_label_encoder.sv @@
// dns_name_label_encoder: top level, host name characters in, DNS wire bytes out.
// Depends on dnle_pkg, dnle_front, dnle_queue and dnle_back.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tdata char_in[7:0], tuser func
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata out_byte[7:0], tlast last,
//           |           |                       | tuser overflow
//
// A character request is written straight into the label memory. A dot or
// end of name queues a close; the back end then emits the length byte and one
// held character per cycle from the label memory read port while rsp_tready
// does not stall the output register, plus the terminator for end of name.
// Two label banks let the front fill one while the other drains; requests
// stall only when two closes are queued.
// Reset is synchronous; no memory clearing pass is needed.

module dns_name_label_encoder #(
   parameter int LABEL_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tuser,   // [0] func
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] overflow
);

   logic                 q_full, q_empty, push, pop;
   dnle_pkg::cmd_type    push_cmd, head;
   dnle_pkg::mem_wr_type mem_wr;

   dnle_front #(.LABEL_MAX(LABEL_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .mem_wr     (mem_wr)
   );

   dnle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dnle_back #(.LABEL_MAX(LABEL_MAX)) u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_wr     (mem_wr),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/dnle_checker.sv @@
// dnle_checker: port-level assertions for dns_name_label_encoder, with bind.
// Depends on the top level's port list only.

module dnle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
                                    && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // overflow is only flagged on the terminator
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("overflow flag off the terminator");

   // the terminator is a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'h00)
      else $error("terminator byte not zero");

   // no result straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
